[rtl/hhd_pkg.sv]
`default_nettype none

package hhd_pkg;

    localparam int BYTE_W = 8;
    localparam int TYPE_W = 3;
    localparam int LEN_W  = 16;
    localparam int POS_W  = 17;
    localparam int HDR_W  = 3;

    // action codes
    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // H4 packet indicators
    localparam logic [TYPE_W-1:0] PKT_NONE = 3'd0;
    localparam logic [TYPE_W-1:0] PKT_CMD  = 3'd1;
    localparam logic [TYPE_W-1:0] PKT_ACL  = 3'd2;
    localparam logic [TYPE_W-1:0] PKT_SCO  = 3'd3;
    localparam logic [TYPE_W-1:0] PKT_EVT  = 3'd4;
    localparam logic [TYPE_W-1:0] PKT_ISO  = 3'd5;

    localparam logic [HDR_W-1:0] HDR_LEN_EVT   = 3'd3;
    localparam logic [HDR_W-1:0] HDR_LEN_SHORT = 3'd4;
    localparam logic [HDR_W-1:0] HDR_LEN_LONG  = 3'd5;

    // byte positions within a frame
    localparam logic [POS_W-1:0] POS_TYPE  = 17'd0;
    localparam logic [POS_W-1:0] POS_1     = 17'd1;
    localparam logic [POS_W-1:0] POS_2     = 17'd2;
    localparam logic [POS_W-1:0] POS_3     = 17'd3;
    localparam logic [POS_W-1:0] POS_4     = 17'd4;
    localparam logic [POS_W-1:0] POS_5     = 17'd5;
    localparam logic [POS_W-1:0] POS_6     = 17'd6;
    localparam logic [POS_W-1:0] POS_7     = 17'd7;
    localparam logic [POS_W-1:0] POS_MASK  = 17'd9;
    localparam logic [POS_W-1:0] MIN_FEAT_TOTAL = 17'd17;

    // Command Complete pattern for the sync train feature fixup
    localparam logic [BYTE_W-1:0] FEAT_B1 = 8'h0e;
    localparam logic [BYTE_W-1:0] FEAT_B4 = 8'h04;
    localparam logic [BYTE_W-1:0] FEAT_B5 = 8'h10;
    localparam logic [BYTE_W-1:0] FEAT_B6 = 8'h00;
    localparam logic [BYTE_W-1:0] FEAT_B7 = 8'h02;
    localparam int                FEAT_BIT = 2;

    // hardware error event: 04 10 01
    localparam logic [BYTE_W-1:0] HWERR_B0 = 8'h04;
    localparam logic [BYTE_W-1:0] HWERR_B1 = 8'h10;
    localparam logic [BYTE_W-1:0] HWERR_B2 = 8'h01;

    typedef struct packed {
        logic                forwarded;
        logic [BYTE_W-1:0]   out_byte;
        logic [TYPE_W-1:0]   packet_type;
        logic                last_byte;
        logic                controller_reset;
        logic                feature_masked;
        logic                resync_drop;
    } t_result;

    function automatic logic [HDR_W-1:0] header_len(input logic [TYPE_W-1:0] t);
        logic [HDR_W-1:0] h;
        h = HDR_LEN_SHORT;
        if (t == PKT_EVT) begin
            h = HDR_LEN_EVT;
        end else if (t == PKT_ACL || t == PKT_ISO) begin
            h = HDR_LEN_LONG;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

[rtl/hhd_frame.sv]
`default_nettype none

module hhd_frame (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_step,
    input  wire logic                   i_action,
    input  wire logic [7:0]             i_byte,
    output hhd_pkg::t_result            o_result
);
    import hhd_pkg::*;

    logic [POS_W-1:0]  r_pos,  n_pos;
    logic [TYPE_W-1:0] r_type, n_type;
    logic [LEN_W-1:0]  r_len,  n_len;
    logic              r_feat, n_feat;
    logic              r_hw,   n_hw;

    logic [HDR_W-1:0]  w_hdr;
    logic [POS_W-1:0]  w_pos_inc;
    logic [POS_W-1:0]  w_total;
    logic              w_last;
    t_result           w_res;

    always_comb begin
        n_pos     = r_pos;
        n_type    = r_type;
        n_len     = r_len;
        n_feat    = r_feat;
        n_hw      = r_hw;
        w_res     = '0;
        w_hdr     = header_len(r_type);
        w_pos_inc = r_pos + POS_W'(1);
        w_total   = '0;
        w_last    = 1'b0;

        if (i_action == ACT_FLUSH) begin
            n_pos  = '0;
            n_type = PKT_NONE;
            n_len  = '0;
            n_feat = 1'b0;
            n_hw   = 1'b0;
        end else if (r_pos == POS_TYPE) begin
            if (i_byte < BYTE_W'(PKT_CMD) || i_byte > BYTE_W'(PKT_ISO)) begin
                w_res.resync_drop = 1'b1;
            end else begin
                n_type = i_byte[TYPE_W-1:0];
                n_len  = '0;
                n_feat = 1'b1;
                n_hw   = (i_byte == HWERR_B0);
                n_pos  = POS_1;
                w_res.forwarded   = 1'b1;
                w_res.out_byte    = i_byte;
                w_res.packet_type = i_byte[TYPE_W-1:0];
            end
        end else begin
            // length field
            if (r_type == PKT_EVT) begin
                if (r_pos == POS_2) begin
                    n_len = LEN_W'(i_byte);
                end
            end else if (r_pos == POS_3) begin
                n_len = LEN_W'(i_byte);
            end else if (r_pos == POS_4 && (r_type == PKT_ACL || r_type == PKT_ISO)) begin
                n_len = {i_byte, r_len[7:0]};
            end

            // pattern tracking
            if (r_pos == POS_1) begin
                if (i_byte != FEAT_B1)  n_feat = 1'b0;
                if (i_byte != HWERR_B1) n_hw   = 1'b0;
            end else if (r_pos == POS_2) begin
                if (i_byte != HWERR_B2) n_hw   = 1'b0;
            end else if (r_pos == POS_4) begin
                if (i_byte != FEAT_B4)  n_feat = 1'b0;
            end else if (r_pos == POS_5) begin
                if (i_byte != FEAT_B5)  n_feat = 1'b0;
            end else if (r_pos == POS_6) begin
                if (i_byte != FEAT_B6)  n_feat = 1'b0;
            end else if (r_pos == POS_7) begin
                if (i_byte != FEAT_B7)  n_feat = 1'b0;
            end

            w_total = POS_W'(w_hdr) + POS_W'(n_len);

            w_res.forwarded   = 1'b1;
            w_res.out_byte    = i_byte;
            w_res.packet_type = r_type;

            if (r_pos == POS_MASK && n_feat && w_total >= MIN_FEAT_TOTAL
                && i_byte[FEAT_BIT]) begin
                w_res.out_byte[FEAT_BIT] = 1'b0;
                w_res.feature_masked     = 1'b1;
            end

            w_last = (w_pos_inc >= POS_W'(w_hdr)) && (w_pos_inc == w_total);

            if (w_last) begin
                w_res.last_byte        = 1'b1;
                w_res.controller_reset = n_hw;
                n_pos  = '0;
                n_type = PKT_NONE;
                n_len  = '0;
                n_feat = 1'b0;
                n_hw   = 1'b0;
            end else begin
                n_pos = w_pos_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_type <= PKT_NONE;
            r_len  <= '0;
            r_feat <= 1'b0;
            r_hw   <= 1'b0;
        end else if (i_step) begin
            r_pos  <= n_pos;
            r_type <= n_type;
            r_len  <= n_len;
            r_feat <= n_feat;
            r_hw   <= n_hw;
        end
    end

    assign o_result = w_res;

endmodule

`default_nettype wire

[rtl/hhd_out_stage.sv]
`default_nettype none

module hhd_out_stage (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_take,
    input  wire hhd_pkg::t_result       i_result,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output hhd_pkg::t_result            o_result
);
    import hhd_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_take = i_valid && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

[rtl/hci_h4_deframer.sv]
// H4 deframer for the controller-to-host direction: takes one byte (or a flush) per
// transaction and returns exactly one result per transaction, tagged with the frame's
// packet type, an end-of-frame mark, a hardware-error flag on the last byte of an
// 04 10 01 event, a flag when the sync train feature bit was cleared, and a drop flag for
// an unknown type byte at a frame start. Throughput is one transaction per clock while the
// result side is ready; from input acceptance to output valid a transaction goes through the
// input register, one pass of framing logic, and the output register. A flush returns an
// all-zero result and puts the framer back to waiting for a type byte.
`default_nettype none

module hci_h4_deframer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_action,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_forwarded,
    output logic [7:0]       o_out_byte,
    output logic [2:0]       o_packet_type,
    output logic             o_last_byte,
    output logic             o_controller_reset,
    output logic             o_feature_masked,
    output logic             o_resync_drop
);
    import hhd_pkg::*;

    logic              r_in_valid;
    logic              r_action;
    logic [BYTE_W-1:0] r_byte;
    logic              w_take;
    t_result           w_res;
    t_result           w_out;

    assign o_in_ready = !r_in_valid || w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_action <= i_action;
            r_byte   <= i_in_byte;
        end
    end

    hhd_frame u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_take),
        .i_action (r_action),
        .i_byte   (r_byte),
        .o_result (w_res)
    );

    hhd_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .o_take   (w_take),
        .i_result (w_res),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (w_out)
    );

    assign o_forwarded        = w_out.forwarded;
    assign o_out_byte         = w_out.out_byte;
    assign o_packet_type      = w_out.packet_type;
    assign o_last_byte        = w_out.last_byte;
    assign o_controller_reset = w_out.controller_reset;
    assign o_feature_masked   = w_out.feature_masked;
    assign o_resync_drop      = w_out.resync_drop;

    a_hwerr_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_controller_reset |-> o_last_byte && o_forwarded)
        else $error("controller reset flag off the last byte");

    a_mask_clears_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_feature_masked |-> o_forwarded && !o_out_byte[FEAT_BIT])
        else $error("masked byte still has feature bit set");

    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_resync_drop |-> !o_forwarded && o_packet_type == PKT_NONE)
        else $error("dropped byte carries frame data");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && o_out_valid && !i_out_ready)
        else $error("input stalled without downstream backpressure");

endmodule

`default_nettype wire

[sim/tb_hci_h4_deframer.sv]
`default_nettype none

module tb_hci_h4_deframer;
    import hhd_pkg::*;

    // Deframer state tracker plus the queue of results still owed by the block.
    class h4_frame_tracker;
        t_result           expected_q[$];
        int                fail_count;
        logic [POS_W-1:0]  frame_pos;
        logic [TYPE_W-1:0] cur_type;
        logic [LEN_W-1:0]  pay_len;
        logic              feat_ok;
        logic              hwerr_ok;

        function new();
            fail_count = 0;
            clear_framing();
        endfunction

        function void clear_framing();
            frame_pos = POS_TYPE;
            cur_type  = PKT_NONE;
            pay_len   = '0;
            feat_ok   = 1'b0;
            hwerr_ok  = 1'b0;
        endfunction

        function void note_input(logic act, logic [BYTE_W-1:0] b);
            t_result r;
            int      hdr;
            int      total;
            int      nxt;
            r = '0;
            if (act == ACT_FLUSH) begin
                clear_framing();
            end else if (frame_pos == POS_TYPE) begin
                if (b == PKT_NONE || b > PKT_ISO) begin
                    r.resync_drop = 1'b1;
                end else begin
                    cur_type      = b[TYPE_W-1:0];
                    pay_len       = '0;
                    feat_ok       = 1'b1;
                    hwerr_ok      = (b == HWERR_B0);
                    frame_pos     = POS_1;
                    r.forwarded   = 1'b1;
                    r.out_byte    = b;
                    r.packet_type = cur_type;
                end
            end else begin
                if (cur_type == PKT_EVT) begin
                    hdr = HDR_LEN_EVT;
                end else if (cur_type == PKT_ACL || cur_type == PKT_ISO) begin
                    hdr = HDR_LEN_LONG;
                end else begin
                    hdr = HDR_LEN_SHORT;
                end
                // length field
                if (cur_type == PKT_EVT) begin
                    if (frame_pos == POS_2) pay_len = {8'd0, b};
                end else if (frame_pos == POS_3) begin
                    pay_len = {8'd0, b};
                end else if (frame_pos == POS_4 && hdr == HDR_LEN_LONG) begin
                    pay_len[15:8] = b;
                end
                case (frame_pos)
                    POS_1: begin
                        if (b != FEAT_B1) feat_ok = 1'b0;
                        if (b != HWERR_B1) hwerr_ok = 1'b0;
                    end
                    POS_2: if (b != HWERR_B2) hwerr_ok = 1'b0;
                    POS_4: if (b != FEAT_B4) feat_ok = 1'b0;
                    POS_5: if (b != FEAT_B5) feat_ok = 1'b0;
                    POS_6: if (b != FEAT_B6) feat_ok = 1'b0;
                    POS_7: if (b != FEAT_B7) feat_ok = 1'b0;
                    default: ;
                endcase
                total         = hdr + int'(pay_len);
                r.forwarded   = 1'b1;
                r.out_byte    = b;
                r.packet_type = cur_type;
                if (frame_pos == POS_MASK && feat_ok && total >= int'(MIN_FEAT_TOTAL)
                    && b[FEAT_BIT]) begin
                    r.out_byte[FEAT_BIT] = 1'b0;
                    r.feature_masked     = 1'b1;
                end
                nxt = int'(frame_pos) + 1;
                if (nxt >= hdr && nxt == total) begin
                    r.last_byte        = 1'b1;
                    r.controller_reset = hwerr_ok;
                    clear_framing();
                end else begin
                    frame_pos = POS_W'(nxt);
                end
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (expected_q.size() == 0) begin
                $error("result transaction with none expected");
                fail_count++;
                return;
            end
            exp = expected_q.pop_front();
            if (got.forwarded !== exp.forwarded) begin
                $error("forwarded: expected %0d, got %0d", exp.forwarded, got.forwarded);
                fail_count++;
            end
            if (got.out_byte !== exp.out_byte) begin
                $error("out_byte: expected %02h, got %02h", exp.out_byte, got.out_byte);
                fail_count++;
            end
            if (got.packet_type !== exp.packet_type) begin
                $error("packet_type: expected %0d, got %0d", exp.packet_type, got.packet_type);
                fail_count++;
            end
            if (got.last_byte !== exp.last_byte) begin
                $error("last_byte: expected %0d, got %0d", exp.last_byte, got.last_byte);
                fail_count++;
            end
            if (got.controller_reset !== exp.controller_reset) begin
                $error("controller_reset: expected %0d, got %0d",
                       exp.controller_reset, got.controller_reset);
                fail_count++;
            end
            if (got.feature_masked !== exp.feature_masked) begin
                $error("feature_masked: expected %0d, got %0d",
                       exp.feature_masked, got.feature_masked);
                fail_count++;
            end
            if (got.resync_drop !== exp.resync_drop) begin
                $error("resync_drop: expected %0d, got %0d", exp.resync_drop, got.resync_drop);
                fail_count++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              i_action = ACT_BYTE;
    logic [7:0]        i_in_byte = 8'h00;
    logic              i_out_ready = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic              o_forwarded;
    logic [7:0]        o_out_byte;
    logic [2:0]        o_packet_type;
    logic              o_last_byte;
    logic              o_controller_reset;
    logic              o_feature_masked;
    logic              o_resync_drop;

    h4_frame_tracker   tracker;
    logic [7:0]        frame_bytes[$];
    int                burst_left = 0;
    int                items_sent = 0;
    logic [15:0]       stall_pat = '1;
    int                stall_phase = 0;

    hci_h4_deframer dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_action           (i_action),
        .i_in_byte          (i_in_byte),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_forwarded        (o_forwarded),
        .o_out_byte         (o_out_byte),
        .o_packet_type      (o_packet_type),
        .o_last_byte        (o_last_byte),
        .o_controller_reset (o_controller_reset),
        .o_feature_masked   (o_feature_masked),
        .o_resync_drop      (o_resync_drop)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1000000;
        $display("FAILURE");
        $finish;
    end

    // result side: check accepted transactions, stall on a rolling pattern
    always @(posedge i_clk) begin : rx_side
        t_result got;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = {o_forwarded, o_out_byte, o_packet_type, o_last_byte,
                       o_controller_reset, o_feature_masked, o_resync_drop};
                tracker.check_result(got);
            end
            if (stall_phase == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pat = '1;
                    1: stall_pat = 16'($urandom) & 16'($urandom);
                    default: stall_pat = 16'($urandom);
                endcase
            end
            i_out_ready <= stall_pat[stall_phase[3:0]];
            stall_phase = (stall_phase + 1) % 64;
        end
    end

    task automatic send_item(input logic act, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_in_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_input(act, b);
        items_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.expected_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_frame(input int n);
        for (int k = 0; k < n; k++) send_item(ACT_BYTE, frame_bytes[k]);
    endtask

    task automatic send_flush();
        send_item(ACT_FLUSH, 8'($urandom));
    endtask

    function automatic int hdr_of(logic [2:0] ptype);
        if (ptype == PKT_EVT) return HDR_LEN_EVT;
        if (ptype == PKT_ACL || ptype == PKT_ISO) return HDR_LEN_LONG;
        return HDR_LEN_SHORT;
    endfunction

    // random frame of the given type and length field
    function automatic void build_frame(logic [2:0] ptype, logic [15:0] plen);
        int hdr;
        hdr = hdr_of(ptype);
        frame_bytes.delete();
        frame_bytes.push_back({5'd0, ptype});
        for (int k = 1; k < hdr + int'(plen); k++) frame_bytes.push_back(8'($urandom));
        if (ptype == PKT_EVT) begin
            frame_bytes[2] = plen[7:0];
        end else begin
            frame_bytes[3] = plen[7:0];
            if (hdr == HDR_LEN_LONG) frame_bytes[4] = plen[15:8];
        end
    endfunction

    function automatic void put_feature_pattern();
        frame_bytes[1] = FEAT_B1;
        frame_bytes[4] = FEAT_B4;
        frame_bytes[5] = FEAT_B5;
        frame_bytes[6] = FEAT_B6;
        frame_bytes[7] = FEAT_B7;
    endfunction

    task automatic random_traffic(input int stop_at);
        int          kind;
        int          total;
        int          n;
        int          next_drain;
        logic [2:0]  ptype;
        logic [15:0] plen;
        logic [7:0]  b2;
        next_drain = items_sent + 100;
        while (items_sent < stop_at) begin
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                repeat ($urandom_range(1, 3)) send_item(ACT_BYTE, 8'($urandom));
                if ($urandom_range(0, 1) == 0) send_flush();
            end else if (kind < 14) begin
                send_flush();
            end else begin
                if (kind < 32) begin
                    case ($urandom_range(0, 2))
                        0: ptype = PKT_CMD;
                        1: ptype = PKT_SCO;
                        default: ptype = PKT_EVT;
                    endcase
                    total = $urandom_range(14, 22);
                    build_frame(ptype, 16'(total - hdr_of(ptype)));
                    put_feature_pattern();
                    if ($urandom_range(0, 3) == 0) begin
                        case ($urandom_range(0, 4))
                            0: frame_bytes[1] = 8'($urandom);
                            1: frame_bytes[4] = 8'($urandom);
                            2: frame_bytes[5] = 8'($urandom);
                            3: frame_bytes[6] = 8'($urandom);
                            default: frame_bytes[7] = 8'($urandom);
                        endcase
                    end
                    frame_bytes[9] = 8'($urandom);
                    if ($urandom_range(0, 3) != 0) frame_bytes[9][FEAT_BIT] = 1'b1;
                end else if (kind < 42) begin
                    b2 = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 4)) : HWERR_B2;
                    build_frame(PKT_EVT, {8'd0, b2});
                    frame_bytes[1] = ($urandom_range(0, 4) == 0) ? 8'($urandom) : HWERR_B1;
                end else begin
                    ptype = 3'($urandom_range(PKT_CMD, PKT_ISO));
                    plen  = 16'($urandom_range(0, 12));
                    if (hdr_of(ptype) == HDR_LEN_LONG && $urandom_range(0, 7) == 0)
                        plen[15:8] = 8'($urandom_range(1, 255));
                    build_frame(ptype, plen);
                end
                total = frame_bytes.size();
                n = total;
                if (total > 300) begin
                    // long length field: go past where a low-byte-only length would end
                    n = hdr_of(frame_bytes[0][2:0]) + int'(frame_bytes[3])
                        + $urandom_range(1, 8);
                end else if (total > 1 && $urandom_range(0, 7) == 0) begin
                    n = $urandom_range(1, total - 1);
                end
                send_frame(n);
                if (n < total) send_flush();
            end
            if (items_sent >= next_drain) begin
                drain();
                next_drain = items_sent + 100;
            end
        end
    endtask

    initial begin
        tracker = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unknown type bytes
        send_item(ACT_BYTE, 8'h00);
        send_item(ACT_BYTE, 8'hff);
        send_item(ACT_BYTE, 8'h06);
        // hardware error event
        build_frame(PKT_EVT, 16'd1);
        frame_bytes[1] = HWERR_B1;
        frame_bytes[3] = 8'hff;
        send_frame(frame_bytes.size());
        // flush mid-frame
        build_frame(PKT_CMD, 16'd5);
        send_frame(2);
        send_flush();
        // sync train bit fixup at the minimum frame length
        build_frame(PKT_EVT, 16'd14);
        put_feature_pattern();
        frame_bytes[9] = 8'hff;
        send_frame(frame_bytes.size());
        drain();

        random_traffic(items_sent + 100);

        // full frame with a nonzero upper length byte, then a short one
        build_frame(PKT_ISO, 16'h0100);
        send_frame(frame_bytes.size());
        build_frame(PKT_ACL, 16'd0);
        send_frame(frame_bytes.size());

        drain();
        repeat (8) @(posedge i_clk);
        if (tracker.fail_count == 0 && tracker.expected_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
